@@ hdl/dxt_pkg.sv @@
// Shared types, format codes and weight tables for the DXT texel decoder.
package dxt_pkg;

  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  // Colour code {four_colour, index}: three-colour mode with index 3 is black.
  localparam logic [2:0] CCODE_BLACK = 3'd3;

  typedef struct packed {
    logic [1:0] fmt;
    logic [2:0] ccode;
    logic [4:0] r0;
    logic [4:0] r1;
    logic [5:0] g0;
    logic [5:0] g1;
    logic [4:0] b0;
    logic [4:0] b1;
    logic [3:0] nib;
    logic [3:0] acode;
    logic [7:0] a0;
    logic [7:0] a1;
  } s1_t;

  typedef struct packed {
    logic [1:0]  fmt;
    logic [2:0]  ccode;
    logic [6:0]  rs;
    logic [7:0]  gs;
    logic [6:0]  bs;
    logic [8:0]  cm;
    logic [3:0]  nib;
    logic [10:0] as;
    logic [8:0]  am;
    logic        aforce;
  } s2_t;

  typedef struct packed {
    logic [1:0]  fmt;
    logic [2:0]  ccode;
    logic [15:0] rp;
    logic [16:0] gp;
    logic [15:0] bp;
    logic [19:0] ap;
    logic        aforce;
    logic [7:0]  a3;
  } s3_t;

  // Colour endpoint weights and reciprocal scale, indexed by colour code.
  function automatic logic [1:0] col_n0(input logic [2:0] code);
    logic [1:0] w;
    case (code)
      3'd0: w = 2'd1;
      3'd2: w = 2'd1;
      3'd4: w = 2'd1;
      3'd6: w = 2'd2;
      3'd7: w = 2'd1;
      default: w = 2'd0;
    endcase
    return w;
  endfunction

  function automatic logic [1:0] col_n1(input logic [2:0] code);
    logic [1:0] w;
    case (code)
      3'd1: w = 2'd1;
      3'd2: w = 2'd1;
      3'd5: w = 2'd1;
      3'd6: w = 2'd1;
      3'd7: w = 2'd2;
      default: w = 2'd0;
    endcase
    return w;
  endfunction

  function automatic logic [8:0] col_m(input logic [2:0] code);
    logic [8:0] m;
    case (code)
      3'd2: m = 9'd128;
      3'd3: m = 9'd0;
      3'd6: m = 9'd86;
      3'd7: m = 9'd86;
      default: m = 9'd256;
    endcase
    return m;
  endfunction

  // Alpha endpoint weights and scale, indexed by {eight_value, selector}.
  function automatic logic [2:0] alp_n0(input logic [3:0] code);
    logic [2:0] w;
    case (code)
      4'd0:  w = 3'd1;
      4'd2:  w = 3'd4;
      4'd3:  w = 3'd3;
      4'd4:  w = 3'd2;
      4'd5:  w = 3'd1;
      4'd8:  w = 3'd1;
      4'd10: w = 3'd6;
      4'd11: w = 3'd5;
      4'd12: w = 3'd4;
      4'd13: w = 3'd3;
      4'd14: w = 3'd2;
      4'd15: w = 3'd1;
      default: w = 3'd0;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] alp_n1(input logic [3:0] code);
    logic [2:0] w;
    case (code)
      4'd1:  w = 3'd1;
      4'd2:  w = 3'd1;
      4'd3:  w = 3'd2;
      4'd4:  w = 3'd3;
      4'd5:  w = 3'd4;
      4'd9:  w = 3'd1;
      4'd10: w = 3'd1;
      4'd11: w = 3'd2;
      4'd12: w = 3'd3;
      4'd13: w = 3'd4;
      4'd14: w = 3'd5;
      4'd15: w = 3'd6;
      default: w = 3'd0;
    endcase
    return w;
  endfunction

  function automatic logic [8:0] alp_m(input logic [3:0] code);
    logic [8:0] m;
    case (code)
      4'd0, 4'd1, 4'd8, 4'd9:    m = 9'd256;
      4'd2, 4'd3, 4'd4, 4'd5:    m = 9'd52;
      4'd6, 4'd7:                m = 9'd0;
      default:                   m = 9'd37;
    endcase
    return m;
  endfunction

  // Six-value mode, selector 7: fully opaque.
  function automatic logic alp_force(input logic [3:0] code);
    return (code == 4'd7);
  endfunction

endpackage

@@ hdl/dxt_texel_decoder.sv @@
// S3TC (DXT1/DXT3/DXT5) single-texel decoder, four-stage pipeline.
// An accepted word passes the stage 1, 2 and 3 registers and the output registers before result_valid rises.
// Throughput: one texel per cycle when result_stall is low; a single-pass stage chain, no unit is shared.
// A result stall holds full stages that have no empty stage downstream; with all four full it raises texel_stall.
// Reset (rst, synchronous, active high) empties every stage and sets block_format to DXT1.
// The configuration channel is always ready; the format is sampled as each word enters.
module dxt_texel_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        texel_valid,
  output logic        texel_stall,
  input  logic [63:0] color_block,
  input  logic [63:0] alpha_block,
  input  logic [1:0]  texel_x,
  input  logic [1:0]  texel_y,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha_out
);
  import dxt_pkg::*;

  // Format register. Writes must only arrive while the pipeline is empty; the block itself does not enforce this.
  logic [1:0] block_format;

  // Stage registers with their valid bits.
  logic v1, v2, v3;
  s1_t  st1;
  s2_t  st2;
  s3_t  st3;

  // A stage may load when it is empty or when its contents move on this cycle.
  logic rdy_out, rdy3, rdy2, rdy1;

  assign rdy_out     = !result_valid || !result_stall;
  assign rdy3        = !v3 || rdy_out;
  assign rdy2        = !v2 || rdy3;
  assign rdy1        = !v1 || rdy2;
  assign texel_stall = !rdy1;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_format <= FMT_DXT1;
    end else if (cfg_valid && cfg_ready) begin
      block_format <= cfg_data;
    end
  end

  // Stage 1: pick out this texel's indices and split the endpoints.
  logic [3:0]  pos;
  logic [15:0] c0, c1;
  logic [1:0]  cidx;
  logic [2:0]  asel;
  s1_t         st1_next;

  always_comb begin
    pos  = {texel_y, texel_x};
    c0   = color_block[15:0];
    c1   = color_block[31:16];
    cidx = color_block[32 + 2 * pos +: 2];
    asel = alpha_block[16 + 3 * pos +: 3];
    st1_next.fmt   = block_format;
    // Four-colour mode when colour0 is strictly greater than colour1.
    st1_next.ccode = {(c0 > c1), cidx};
    st1_next.r0    = c0[15:11];
    st1_next.g0    = c0[10:5];
    st1_next.b0    = c0[4:0];
    st1_next.r1    = c1[15:11];
    st1_next.g1    = c1[10:5];
    st1_next.b1    = c1[4:0];
    st1_next.nib   = alpha_block[4 * pos +: 4];
    st1_next.a0    = alpha_block[7:0];
    st1_next.a1    = alpha_block[15:8];
    // Eight-value alpha mode when alpha0 is strictly greater than alpha1.
    st1_next.acode = {(alpha_block[7:0] > alpha_block[15:8]), asel};
  end

  // Stage 2: weighted endpoint sums; the weights are at most two (colour) or six (alpha).
  s2_t st2_next;

  always_comb begin
    st2_next.fmt    = st1.fmt;
    st2_next.ccode  = st1.ccode;
    st2_next.rs     = 7'(st1.r0) * 7'(col_n0(st1.ccode)) + 7'(st1.r1) * 7'(col_n1(st1.ccode));
    st2_next.gs     = 8'(st1.g0) * 8'(col_n0(st1.ccode)) + 8'(st1.g1) * 8'(col_n1(st1.ccode));
    st2_next.bs     = 7'(st1.b0) * 7'(col_n0(st1.ccode)) + 7'(st1.b1) * 7'(col_n1(st1.ccode));
    st2_next.cm     = col_m(st1.ccode);
    st2_next.nib    = st1.nib;
    st2_next.as     = 11'(st1.a0) * 11'(alp_n0(st1.acode))
                    + 11'(st1.a1) * 11'(alp_n1(st1.acode));
    st2_next.am     = alp_m(st1.acode);
    st2_next.aforce = alp_force(st1.acode);
  end

  // Stage 3: scale by the reciprocal constants. DXT3 alpha is the nibble repeated.
  s3_t st3_next;

  always_comb begin
    st3_next.fmt    = st2.fmt;
    st3_next.ccode  = st2.ccode;
    st3_next.rp     = 16'(st2.rs) * 16'(st2.cm);
    st3_next.gp     = 17'(st2.gs) * 17'(st2.cm);
    st3_next.bp     = 16'(st2.bs) * 16'(st2.cm);
    st3_next.ap     = 20'(st2.as) * 20'(st2.am);
    st3_next.aforce = st2.aforce;
    st3_next.a3     = {st2.nib, st2.nib};
  end

  // Stage 4: shift down, saturate DXT5 alpha and choose the alpha source by format.
  logic [11:0] a5_wide;
  logic [7:0]  a5;
  logic [7:0]  alpha_next;

  always_comb begin
    a5_wide = st3.ap[19:8];
    if (st3.aforce || (a5_wide > 12'd255)) begin
      a5 = 8'hFF;
    end else begin
      a5 = a5_wide[7:0];
    end
    case (st3.fmt)
      FMT_DXT1: begin
        // Punch-through: the black entry of the three-colour mode is transparent.
        alpha_next = (st3.ccode == CCODE_BLACK) ? 8'h00 : 8'hFF;
      end
      FMT_DXT3: begin
        alpha_next = st3.a3;
      end
      default: begin
        alpha_next = a5;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= texel_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy_out) begin
        result_valid <= v3;
      end
    end
  end

  // Payload registers load with their stage and need no reset.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      st1 <= st1_next;
    end
    if (rdy2) begin
      st2 <= st2_next;
    end
    if (rdy3) begin
      st3 <= st3_next;
    end
    if (rdy_out) begin
      red       <= st3.rp[12:5];
      green     <= st3.gp[13:6];
      blue      <= st3.bp[12:5];
      alpha_out <= alpha_next;
    end
  end

  // A full first stage that cannot move on keeps its word.
  assert property (@(posedge clk) disable iff (rst)
    v1 && !rdy2 |=> v1 && $stable(st1))
    else $error("stage 1 word lost or changed under stall");

  // A full third stage that cannot move on keeps its word.
  assert property (@(posedge clk) disable iff (rst)
    v3 && !rdy_out |=> v3 && $stable(st3))
    else $error("stage 3 word lost or changed under stall");

  // Opaque DXT1 texels leave with full alpha.
  assert property (@(posedge clk) disable iff (rst)
    v3 && rdy_out && (st3.fmt == FMT_DXT1) && (st3.ccode != CCODE_BLACK)
    |=> alpha_out == 8'hFF)
    else $error("DXT1 opaque texel without full alpha");

  // The black entry of the three-colour mode gives zero colour.
  assert property (@(posedge clk) disable iff (rst)
    v3 && rdy_out && (st3.ccode == CCODE_BLACK)
    |=> (red == 8'd0) && (green == 8'd0) && (blue == 8'd0))
    else $error("three-colour black entry not black");

  // DXT3 alpha is a nibble times seventeen, so both halves match.
  assert property (@(posedge clk) disable iff (rst)
    v3 && rdy_out && (st3.fmt == FMT_DXT3) |=> alpha_out[7:4] == alpha_out[3:0])
    else $error("DXT3 alpha not a repeated nibble");

endmodule
